FILE: design/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection block.
// No dependencies.
package rti_pkg;

    localparam int DIST_W  = 32;    // output distance width
    localparam int EPS_W   = 32;    // epsilon register width
    localparam int QUO_W   = 32;    // quotient bits produced by the divider
    localparam int Q_DEPTH = 4;     // request queue depth
    localparam int Q_AW    = 2;     // queue address width

    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CAUSE_HIT      = 2'd0,
        CAUSE_PARALLEL = 2'd1,
        CAUSE_U_RANGE  = 2'd2,
        CAUSE_V_RANGE  = 2'd3
    } cause_t;

    // classification result carried from front to back
    typedef struct packed {
        cause_t cause;
        logic   neg;    // distance numerator negative
        logic   big;    // quotient does not fit in QUO_W bits
    } ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: design/rti_if.sv
// Request and result channel interfaces (valid/ready).
// Depends on rti_pkg.
interface rti_req_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] edge_one_x;
    logic signed [W-1:0] edge_one_y;
    logic signed [W-1:0] edge_one_z;
    logic signed [W-1:0] edge_two_x;
    logic signed [W-1:0] edge_two_y;
    logic signed [W-1:0] edge_two_z;
    logic signed [W-1:0] origin_rel_x;
    logic signed [W-1:0] origin_rel_y;
    logic signed [W-1:0] origin_rel_z;
    logic signed [W-1:0] direction_x;
    logic signed [W-1:0] direction_y;
    logic signed [W-1:0] direction_z;

    modport source (
        output valid, edge_one_x, edge_one_y, edge_one_z, edge_two_x, edge_two_y,
               edge_two_z, origin_rel_x, origin_rel_y, origin_rel_z,
               direction_x, direction_y, direction_z,
        input  ready
    );
    modport sink (
        input  valid, edge_one_x, edge_one_y, edge_one_z, edge_two_x, edge_two_y,
               edge_two_z, origin_rel_x, origin_rel_y, origin_rel_z,
               direction_x, direction_y, direction_z,
        output ready
    );
endinterface

interface rti_res_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [rti_pkg::DIST_W-1:0] distance;
    logic [1:0]                        miss_cause;

    modport source (output valid, hit, distance, miss_cause, input ready);
    modport sink (input valid, hit, distance, miss_cause, output ready);
endinterface

FILE: design/rti_front.sv
// Front end: request capture, cross/dot product pipeline and hit classification.
// Depends on rti_pkg and rti_if.
module rti_front #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int DW = 3*W+2,
    parameter int NW = DW+F
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rti_req_if.sink                     req,
    input  logic [rti_pkg::EPS_W-1:0]   eps,
    input  logic                        q_full,
    output logic                        push,
    output rti_pkg::ctl_t               ctl,
    output logic [DW-1:0]               det,
    output logic [NW-1:0]               num
);
    localparam int PW   = 2*W;
    localparam int HW   = 2*W+1;
    localparam int CMPW = ((DW > rti_pkg::EPS_W+2*F) ? DW : rti_pkg::EPS_W+2*F) + 1;
    localparam int BW   = DW + rti_pkg::QUO_W;

    logic       en;
    logic [7:1] v_reg;

    // stage 1: captured vectors
    logic signed [W-1:0] e1_1_reg[3], e2_1_reg[3], s_1_reg[3], d_1_reg[3];
    // stage 2: cross products, raw
    logic signed [PW-1:0] ha_reg[3], hb_reg[3], qa_reg[3], qb_reg[3];
    logic signed [W-1:0]  e1_2_reg[3], e2_2_reg[3], s_2_reg[3], d_2_reg[3];
    // stage 3: h and q
    logic signed [HW-1:0] h_reg[3], q_reg[3];
    logic signed [W-1:0]  e1_3_reg[3], e2_3_reg[3], s_3_reg[3], d_3_reg[3];
    // stage 4: split partial products, dot k = det, u, v, t
    logic signed [HW-1:0] pl_reg[4][3], ph_reg[4][3];
    logic signed [W-1:0]  op_a[4][3];
    logic signed [HW-1:0] op_b[4][3];
    // stage 5, 6: dot sums, sign-normalized
    logic signed [DW-1:0] dot5_reg[4], dot5_next[4];
    logic signed [DW-1:0] dot6_reg[4], dot6_next[4];
    // stage 7: classification
    rti_pkg::ctl_t        ctl_reg, ctl_next;
    logic [DW-1:0]        det_reg;
    logic [NW-1:0]        num_reg, num_next;

    logic signed [DW:0]   uv_sum;
    logic signed [DW-1:0] mag;
    logic [CMPW-1:0]      det_c, eps_c;
    logic [BW-1:0]        num_b, det_b;

    assign en        = !v_reg[7] || !q_full;
    assign req.ready = en;
    assign push      = v_reg[7] && !q_full;
    assign ctl       = ctl_reg;
    assign det       = det_reg;
    assign num       = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:1], req.valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            op_a[0][k] = e1_3_reg[k];  op_b[0][k] = h_reg[k];
            op_a[1][k] = s_3_reg[k];   op_b[1][k] = h_reg[k];
            op_a[2][k] = d_3_reg[k];   op_b[2][k] = q_reg[k];
            op_a[3][k] = e2_3_reg[k];  op_b[3][k] = q_reg[k];
        end
        for (int j = 0; j < 4; j++)
        begin
            dot5_next[j] = '0;
            for (int k = 0; k < 3; k++)
            begin
                dot5_next[j] = dot5_next[j] + (DW'(ph_reg[j][k]) <<< W) + DW'(pl_reg[j][k]);
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            dot6_next[j] = dot5_reg[0][DW-1] ? -dot5_reg[j] : dot5_reg[j];
        end
    end

    // classification on the sign-normalized dot products
    always_comb
    begin
        uv_sum = (DW+1)'(dot6_reg[1]) + (DW+1)'(dot6_reg[2]);
        det_c  = CMPW'($unsigned(dot6_reg[0]));
        eps_c  = CMPW'(eps) << (2*F);
        mag    = dot6_reg[3][DW-1] ? -dot6_reg[3] : dot6_reg[3];
        num_next = NW'($unsigned(mag)) << F;
        num_b  = BW'(num_next);
        det_b  = BW'($unsigned(dot6_reg[0])) << rti_pkg::QUO_W;
        ctl_next.neg = dot6_reg[3][DW-1];
        ctl_next.big = (num_b >= det_b);
        priority if ((dot6_reg[0] == '0) || (det_c < eps_c))
        begin
            ctl_next.cause = rti_pkg::CAUSE_PARALLEL;
        end
        else if (dot6_reg[1][DW-1] || (dot6_reg[0] < dot6_reg[1]))
        begin
            ctl_next.cause = rti_pkg::CAUSE_U_RANGE;
        end
        else if (dot6_reg[2][DW-1] || ((DW+1)'(dot6_reg[0]) < uv_sum))
        begin
            ctl_next.cause = rti_pkg::CAUSE_V_RANGE;
        end
        else
        begin
            ctl_next.cause = rti_pkg::CAUSE_HIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_1_reg <= '{req.edge_one_x, req.edge_one_y, req.edge_one_z};
            e2_1_reg <= '{req.edge_two_x, req.edge_two_y, req.edge_two_z};
            s_1_reg  <= '{req.origin_rel_x, req.origin_rel_y, req.origin_rel_z};
            d_1_reg  <= '{req.direction_x, req.direction_y, req.direction_z};
            for (int i = 0; i < 3; i++)
            begin
                // h = d x e2, q = s x e1
                ha_reg[i] <= d_1_reg[(i+1)%3] * e2_1_reg[(i+2)%3];
                hb_reg[i] <= d_1_reg[(i+2)%3] * e2_1_reg[(i+1)%3];
                qa_reg[i] <= s_1_reg[(i+1)%3] * e1_1_reg[(i+2)%3];
                qb_reg[i] <= s_1_reg[(i+2)%3] * e1_1_reg[(i+1)%3];
                h_reg[i]  <= HW'(ha_reg[i]) - HW'(hb_reg[i]);
                q_reg[i]  <= HW'(qa_reg[i]) - HW'(qb_reg[i]);
            end
            e1_2_reg <= e1_1_reg;  e2_2_reg <= e2_1_reg;
            s_2_reg  <= s_1_reg;   d_2_reg  <= d_1_reg;
            e1_3_reg <= e1_2_reg;  e2_3_reg <= e2_2_reg;
            s_3_reg  <= s_2_reg;   d_3_reg  <= d_2_reg;
            // split the wide operand: low W bits unsigned, high W+1 bits signed
            for (int j = 0; j < 4; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pl_reg[j][k] <= HW'(op_a[j][k] * $signed({1'b0, op_b[j][k][W-1:0]}));
                    ph_reg[j][k] <= HW'(op_a[j][k] * $signed(op_b[j][k][HW-1:W]));
                end
            end
            dot5_reg <= dot5_next;
            dot6_reg <= dot6_next;
            ctl_reg  <= ctl_next;
            det_reg  <= $unsigned(dot6_reg[0]);
            num_reg  <= num_next;
        end
    end

endmodule

FILE: design/rti_queue.sv
// Short FIFO decoupling the classification front from the divider back.
// Depends on rti_pkg.
module rti_queue #(
    parameter int EW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [EW-1:0]   wdata,
    input  logic            pop,
    output logic [EW-1:0]   rdata,
    output rti_pkg::qstat_t stat
);
    logic [EW-1:0]             mem_reg[rti_pkg::Q_DEPTH];
    logic [rti_pkg::Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [rti_pkg::Q_AW:0]    count_reg, count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (rti_pkg::Q_AW+1)'(rti_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg + (rti_pkg::Q_AW+1)'(push) - (rti_pkg::Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: design/rti_back.sv
// Back end: pipelined restoring divider for the distance, saturation, result register.
// Depends on rti_pkg and rti_if.
module rti_back #(
    parameter int DW = 98,
    parameter int NW = 114
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    output logic           pop,
    input  rti_pkg::ctl_t  ctl,
    input  logic [DW-1:0]  det,
    input  logic [NW-1:0]  num,
    rti_res_if.source      rsp
);
    localparam int RW = DW + 1;
    localparam int QW = rti_pkg::QUO_W;

    logic                 en;
    logic [QW:0]          v_reg;
    rti_pkg::ctl_t        ctl_reg[QW+1];
    logic [DW-1:0]        det_reg[QW+1];
    logic [RW-1:0]        rem_reg[QW+1], rem_next[QW+1];
    logic [QW-1:0]        nlo_reg[QW+1];
    logic [QW-1:0]        quo_reg[QW+1], quo_next[QW+1];
    logic [RW-1:0]        shifted[QW];

    logic                              out_valid_reg;
    logic                              hit_reg, hit_next;
    logic [rti_pkg::DIST_W-1:0]        dist_reg, dist_next;
    rti_pkg::cause_t                   cause_reg;

    assign en  = !out_valid_reg || rsp.ready;
    assign pop = en && !q_empty;

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.distance   = dist_reg;
    assign rsp.miss_cause = cause_reg;

    // one quotient bit per stage
    always_comb
    begin
        rem_next[0] = RW'(num >> QW);
        quo_next[0] = '0;
        for (int k = 0; k < QW; k++)
        begin
            shifted[k] = {rem_reg[k][RW-2:0], nlo_reg[k][QW-1]};
            if (shifted[k] >= RW'(det_reg[k]))
            begin
                rem_next[k+1] = shifted[k] - RW'(det_reg[k]);
                quo_next[k+1] = {quo_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1] = shifted[k];
                quo_next[k+1] = {quo_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        hit_next  = 1'b0;
        dist_next = '0;
        if (ctl_reg[QW].cause == rti_pkg::CAUSE_HIT)
        begin
            hit_next = 1'b1;
            if (!ctl_reg[QW].neg)
            begin
                dist_next = (ctl_reg[QW].big || quo_reg[QW][QW-1]) ? rti_pkg::DIST_MAX
                                                                    : quo_reg[QW];
            end
            else
            begin
                dist_next = (ctl_reg[QW].big || (quo_reg[QW] > rti_pkg::DIST_MIN))
                          ? rti_pkg::DIST_MIN : -quo_reg[QW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QW-1:0], !q_empty};
            out_valid_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= ctl;
            det_reg[0] <= det;
            nlo_reg[0] <= num[QW-1:0];
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            for (int k = 0; k < QW; k++)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
                det_reg[k+1] <= det_reg[k];
                nlo_reg[k+1] <= nlo_reg[k] << 1;
                rem_reg[k+1] <= rem_next[k+1];
                quo_reg[k+1] <= quo_next[k+1];
            end
            hit_reg   <= hit_next;
            dist_reg  <= dist_next;
            cause_reg <= ctl_reg[QW].cause;
        end
    end

endmodule

FILE: design/ray_triangle_intersect.sv
// Top level of the Moller-Trumbore ray/triangle intersection block.
// Depends on rti_pkg, rti_if, rti_front, rti_queue and rti_back.
//
// One ray/triangle test per request, fully pipelined: a new request can be taken
// every clock, and results come back in request order. A request passes the front
// pipeline stages (capture, cross products, h/q, split partial products, dot sums,
// sign fix, classification), a four-entry queue, then the back pipeline: an input
// register, 32 restoring-division stages for the distance and the result register.
// The front stalls only when the queue is full; the back stalls only when the
// result register holds an untaken result, so result back-pressure reaches the
// request side after the queue fills. Misses (parallel, u or v out of range)
// report hit = 0, distance = 0 and the cause code. parallel_epsilon is written
// through cfg_we/cfg_wdata and resets to 1; write it only while the block is idle.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rti_req_if.sink                   req,
    rti_res_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [rti_pkg::EPS_W-1:0] cfg_wdata
);
    // dot products of a coordinate with a cross product, three terms
    localparam int DW = 3*COORD_WIDTH + 2;
    // distance numerator, |t| scaled by the fraction bits
    localparam int NW = DW + FRACTION_BITS;
    localparam int CW = $bits(rti_pkg::ctl_t);
    localparam int EW = CW + DW + NW;

    logic [rti_pkg::EPS_W-1:0] eps_reg;

    logic            push, pop;
    rti_pkg::ctl_t   f_ctl, b_ctl;
    logic [DW-1:0]   f_det, b_det;
    logic [NW-1:0]   f_num, b_num;
    logic [EW-1:0]   q_rdata;
    rti_pkg::qstat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= rti_pkg::EPS_W'(1);
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    // front: products, sums and hit classification
    rti_front #(
        .W  (COORD_WIDTH),
        .F  (FRACTION_BITS),
        .DW (DW),
        .NW (NW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .eps    (eps_reg),
        .q_full (q_stat.full),
        .push   (push),
        .ctl    (f_ctl),
        .det    (f_det),
        .num    (f_num)
    );

    // queue entry: control, |det|, scaled |t|
    rti_queue #(
        .EW (EW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_ctl, f_det, f_num}),
        .pop   (pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    assign {b_ctl, b_det, b_num} = q_rdata;

    // back: division and saturation of the distance
    rti_back #(
        .DW (DW),
        .NW (NW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_stat.empty),
        .pop     (pop),
        .ctl     (b_ctl),
        .det     (b_det),
        .num     (b_num),
        .rsp     (rsp)
    );

    // a result flags a hit exactly when its cause code says hit
    a_hit_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.hit == (rsp.miss_cause == rti_pkg::CAUSE_HIT)))
        else $error("hit flag and cause code disagree");

    // a miss carries a zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.distance == '0))
        else $error("miss with nonzero distance");

    // queue never reports full and empty together
    a_q_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_stat.empty)
        else $error("queue full and empty at once");

    // a full queue that is not popped does not turn empty
    a_q_push: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pop) |=> !(q_stat.empty))
        else $error("queue lost entries while full");

endmodule

FILE: tb/tb_rti_if.sv
`timescale 1ns / 100ps
// Testbench request and result records for the ray/triangle block.
// The RTL channel interfaces are used directly. Depends on rti_pkg.
package tb_rti_pkg;

    typedef struct {
        logic signed [31:0] e1[3];
        logic signed [31:0] e2[3];
        logic signed [31:0] org[3];
        logic signed [31:0] dir[3];
    } ray_req_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] distance;
        rti_pkg::cause_t    cause;
    } isect_res_t;
endpackage

FILE: tb/tb_ray_triangle_intersect.sv
`timescale 1ns / 100ps
// Self-checking testbench for ray_triangle_intersect: directed table plus random requests,
// exact wide-integer Moller-Trumbore predictor, random valid/ready gaps and back-pressure.
// Depends on rti_pkg, rti_if, tb_rti_pkg and the RTL.
module tb_ray_triangle_intersect;

    localparam int  NRAND     = 1130;
    localparam int  LATENCY   = 60;
    localparam longint LIMIT  = 400000;

    typedef logic signed [255:0] wide_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rti_pkg::EPS_W-1:0] cfg_wdata = '0;

    rti_req_if #(32) req ();
    rti_res_if       rsp ();

    ray_triangle_intersect u_top (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    logic [31:0]              eps_reg;       // predictor copy of parallel_epsilon
    tb_rti_pkg::isect_res_t   expected_q[$];
    int                       fail_count = 0;
    longint                   cycle_count = 0;
    bit                       stall_long = 1'b0;   // receiver holds off for a long stretch
    bit                       drain_done = 1'b0;

    // directed rows: a typed expectation where it is obvious
    typedef struct {
        tb_rti_pkg::ray_req_t   r;
        bit                     has_exp;
        tb_rti_pkg::isect_res_t ex;
    } dir_row_t;
    dir_row_t dir_table[$];

    // ---------------------------------------------------------------
    // Predictor: exact integer Moller-Trumbore
    // ---------------------------------------------------------------
    function automatic tb_rti_pkg::isect_res_t intersect_predict(tb_rti_pkg::ray_req_t r);
        wide_t e1[3], e2[3], s[3], d[3], h[3], q[3];
        wide_t det, un, vn, tn, eps, num, quo;
        bit    tneg;
        tb_rti_pkg::isect_res_t res;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = r.e1[i]; e2[i] = r.e2[i]; s[i] = r.org[i]; d[i] = r.dir[i];
        end
        h[0] = d[1]*e2[2] - d[2]*e2[1];
        h[1] = d[2]*e2[0] - d[0]*e2[2];
        h[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
        un  = s[0]*h[0]  + s[1]*h[1]  + s[2]*h[2];
        vn  = d[0]*q[0]  + d[1]*q[1]  + d[2]*q[2];
        tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det < 0)
        begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        res.hit = 1'b0;
        res.distance = '0;
        eps = wide_t'({224'd0, eps_reg}) <<< 32;
        if (det == 0 || det < eps)
            res.cause = rti_pkg::CAUSE_PARALLEL;
        else if (un < 0 || un > det)
            res.cause = rti_pkg::CAUSE_U_RANGE;
        else if (vn < 0 || un + vn > det)
            res.cause = rti_pkg::CAUSE_V_RANGE;
        else
        begin
            tneg = tn < 0;
            num = (tneg ? -tn : tn) <<< 16;
            quo = num / det;
            res.hit = 1'b1;
            res.cause = rti_pkg::CAUSE_HIT;
            if (!tneg)
                res.distance = (quo > 64'sh7FFF_FFFF) ? rti_pkg::DIST_MAX : quo[31:0];
            else
                res.distance = (quo > 64'sh8000_0000) ? rti_pkg::DIST_MIN : -quo[31:0];
        end
        return res;
    endfunction

    function automatic tb_rti_pkg::ray_req_t make_req(logic signed [31:0] a0, a1, a2,
                                                      b0, b1, b2, c0, c1, c2, d0, d1, d2);
        tb_rti_pkg::ray_req_t r;
        r.e1[0] = a0; r.e1[1] = a1; r.e1[2] = a2;
        r.e2[0] = b0; r.e2[1] = b1; r.e2[2] = b2;
        r.org[0] = c0; r.org[1] = c1; r.org[2] = c2;
        r.dir[0] = d0; r.dir[1] = d1; r.dir[2] = d2;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // well-formed ray aimed into a unit-ish triangle with random scale and jitter, or random coordinates
    function automatic tb_rti_pkg::ray_req_t rand_req();
        tb_rti_pkg::ray_req_t r;
        int sc;
        sc = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.e1[i] = rand_coord(); r.e2[i] = rand_coord();
                r.org[i] = rand_coord(); r.dir[i] = rand_coord();
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.e1[i]  = $signed($urandom_range(0, 32'h0004_0000)) >>> sc;
                r.e2[i]  = $signed($urandom_range(0, 32'h0004_0000)) >>> sc;
                r.org[i] = ($signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_0000) >>> sc;
                r.dir[i] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            end
            r.e1[1] = r.e1[1] >>> 3;
            r.e2[0] = r.e2[0] >>> 3;
            r.dir[2] = -($signed($urandom_range(32'h0000_4000, 32'h0004_0000)));
            r.org[2] = $signed($urandom_range(32'h0000_1000, 32'h0004_0000));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request driver (falling edge)
    // ---------------------------------------------------------------
    task automatic drive_req(tb_rti_pkg::ray_req_t r);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
        @(negedge clk);
        req.valid <= 1'b1;
        req.edge_one_x <= r.e1[0]; req.edge_one_y <= r.e1[1]; req.edge_one_z <= r.e1[2];
        req.edge_two_x <= r.e2[0]; req.edge_two_y <= r.e2[1]; req.edge_two_z <= r.e2[2];
        req.origin_rel_x <= r.org[0]; req.origin_rel_y <= r.org[1];
        req.origin_rel_z <= r.org[2];
        req.direction_x <= r.dir[0]; req.direction_y <= r.dir[1];
        req.direction_z <= r.dir[2];
        // wait for acceptance at a rising edge
        do @(posedge clk); while (!req.ready);
        expected_q.push_back(intersect_predict(r));
    endtask

    task automatic idle_req();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_eps(logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        eps_reg = v;
    endtask

    // ---------------------------------------------------------------
    // Result sink: per-result random wait, then ready until one is taken
    // ---------------------------------------------------------------
    initial
    begin
        int wait_n;
        rsp.ready = 1'b0;
        forever
        begin
            wait_n = $urandom_range(0, 8);
            repeat (wait_n)
            begin
                @(negedge clk);
                rsp.ready <= 1'b0;
            end
            do
            begin
                @(negedge clk);
                rsp.ready <= !stall_long;
                @(posedge clk);
            end
            while (!(rst_n && rsp.valid && rsp.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b dist=%0d cause=%0d", $time,
                         rsp.hit, rsp.distance, rsp.miss_cause);
                fail_count++;
            end
            else
            begin
                tb_rti_pkg::isect_res_t ex;
                ex = expected_q.pop_front();
                if (rsp.hit !== ex.hit || rsp.distance !== ex.distance
                    || rsp.miss_cause !== ex.cause)
                begin
                    $display({"%0t: mismatch expected hit=%0b dist=%0d cause=%0d, ",
                              "got hit=%0b dist=%0d cause=%0d"},
                             $time, ex.hit, ex.distance, ex.cause,
                             rsp.hit, rsp.distance, rsp.miss_cause);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("ray_triangle_intersect verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        dir_row_t row;
        tb_rti_pkg::isect_res_t miss_par;
        logic [31:0] eps_set[4];
        req.valid = 1'b0;
        req.edge_one_x = '0; req.edge_one_y = '0; req.edge_one_z = '0;
        req.edge_two_x = '0; req.edge_two_y = '0; req.edge_two_z = '0;
        req.origin_rel_x = '0; req.origin_rel_y = '0; req.origin_rel_z = '0;
        req.direction_x = '0; req.direction_y = '0; req.direction_z = '0;
        eps_reg = 32'd1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        miss_par.hit = 1'b0; miss_par.distance = '0; miss_par.cause = rti_pkg::CAUSE_PARALLEL;
        // all zero: degenerate, parallel
        row.r = make_req(0,0,0, 0,0,0, 0,0,0, 0,0,0);
        row.has_exp = 1; row.ex = miss_par; dir_table.push_back(row);
        // unit triangle in xy, ray straight down from z=1 through (0.25,0.25): t = 1.0
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h4000,32'h4000,32'h10000,
                         0,0,-32'sh10000);
        row.has_exp = 1; row.ex.hit = 1; row.ex.distance = 32'h10000;
        row.ex.cause = rti_pkg::CAUSE_HIT; dir_table.push_back(row);
        // ray parallel to plane
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 0,0,32'h10000, 32'h10000,0,0);
        row.has_exp = 1; row.ex = miss_par; dir_table.push_back(row);
        // u out of range (negative), u > 1, v negative, u+v > 1
        row.has_exp = 0;
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, -32'sh4000,32'h4000,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h18000,32'h4000,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h4000,-32'sh4000,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'hC000,32'hC000,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        // edge cases u=0, u=1, u+v=1 exactly
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 0,0,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h10000,0,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h8000,32'h8000,32'h10000,
                         0,0,-32'sh10000); dir_table.push_back(row);
        // hit behind origin (negative t)
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h4000,32'h4000,32'h10000,
                         0,0,32'h10000); dir_table.push_back(row);
        // tiny direction: saturates positive and negative
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h4000,32'h4000,32'h7FFF0000,
                         0,0,-32'sh1); dir_table.push_back(row);
        row.r = make_req(32'h10000,0,0, 0,32'h10000,0, 32'h4000,32'h4000,32'h80000000,
                         0,0,-32'sh1); dir_table.push_back(row);
        // small determinant versus reset epsilon
        row.r = make_req(32'h100,0,0, 0,32'h100,0, 32'h40,32'h40,32'h100,
                         0,0,-32'sh100); dir_table.push_back(row);
        // field extremes
        row.r = make_req(32'h7FFFFFFF,32'h80000000,32'h7FFFFFFF, 32'h80000000,32'h7FFFFFFF,
                         32'h80000000, 32'h7FFFFFFF,32'h80000000,32'h7FFFFFFF,
                         32'h80000000,32'h7FFFFFFF,32'h80000000); dir_table.push_back(row);
        row.r = make_req(-1,-1,-1, -1,1,-1, 1,-1,1, -1,-1,1); dir_table.push_back(row);
        row.r = make_req(32'h7FFFFFFF,0,0, 0,32'h7FFFFFFF,0, 32'h1,32'h1,32'h7FFFFFFF,
                         0,0,32'h80000000); dir_table.push_back(row);

        // directed walk; a typed expectation replaces the predictor where given
        foreach (dir_table[i])
        begin
            drive_req(dir_table[i].r);
            if (dir_table[i].has_exp)
                expected_q[expected_q.size()-1] = dir_table[i].ex;
        end
        idle_req();
        wait_drained();

        eps_set[0] = 32'd0;
        eps_set[1] = 32'hFFFF_FFFF;
        eps_set[2] = 32'd1;
        eps_set[3] = 32'h0000_0100;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_eps(eps_set[ph] == 32'd1 ? $urandom_range(0, 32'h40) : eps_set[ph]);
            for (int n = 0; n < NRAND / 4; n++)
            begin
                if (ph == 1 && n == 20)
                begin
                    // long receiver hold-off while requests keep coming
                    fork
                        begin
                            stall_long = 1'b1;
                            repeat (400) @(posedge clk);
                            stall_long = 1'b0;
                        end
                    join_none
                end
                if (n == 150)
                begin
                    // sender pauses until everything has come back
                    idle_req();
                    while (expected_q.size() != 0) @(posedge clk);
                end
                drive_req(rand_req());
            end
            idle_req();
            wait_drained();
        end

        if (fail_count == 0)
            $display("ray_triangle_intersect verification clean");
        else
            $display("ray_triangle_intersect verification failed");
        $finish;
    end
endmodule

FILE: ray_triangle_intersect.f
design/rti_pkg.sv
design/rti_if.sv
design/rti_front.sv
design/rti_queue.sv
design/rti_back.sv
design/ray_triangle_intersect.sv
tb/tb_rti_if.sv
tb/tb_ray_triangle_intersect.sv
